/* src/ip_fragment_slot_table_defines.svh */
// Assertion macros shared by the slot table RTL.
`ifndef IP_FRAGMENT_SLOT_TABLE_DEFINES_SVH
`define IP_FRAGMENT_SLOT_TABLE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define IPFST_ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("ipfst: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define IPFST_ASSERT_NXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("ipfst: next-cycle check failed");

`endif

/* src/ipfst_pkg.sv */
`default_nettype none
package ipfst_pkg;

  localparam int ID_W    = 16;
  localparam int ADDR_W  = 32;
  localparam int PROTO_W = 8;
  localparam int LIFE_W  = 8;
  localparam int KEY_W   = ID_W + 2 * ADDR_W + PROTO_W;
  localparam int ENTRY_W = KEY_W + LIFE_W;
  localparam int OP_W    = 2;
  localparam int REL_W   = 3;
  localparam int SLOT_W  = 3;
  localparam int STAT_W  = 3;
  localparam int MASK_W  = 8;

  localparam logic [LIFE_W-1:0] LIFETIME_RESET = 8'd10;
  localparam logic [LIFE_W-1:0] COUNT_INIT     = 8'hFF;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP,
    OP_TICK,
    OP_RELEASE
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_MATCHED,
    ST_NEW_FREE,
    ST_NEW_EVICT,
    ST_TICK,
    ST_RELEASED
  } status_t;

endpackage
`default_nettype wire

/* src/ip_fragment_slot_table.sv */
// IPv4 reassembly context table.
// Requests enter on s_tvalid/s_tready: s_tuser carries the operation (lookup or
// install, tick, release); s_tdata carries the key and the release slot.
// Each request returns one result on m_tvalid/m_tready (status in m_tuser),
// except the undefined operation, which is dropped without a result.
// Keys and countdowns live in one RAM with a registered read; valid bits are
// flops. Lookup and tick walk the slots one read per cycle, evaluating each
// slot the cycle after its read and writing countdowns back on a tick.
// A lookup stops its walk at the first match; a tick always walks every
// slot.
// One request is in flight at a time; a new request is taken once the
// previous result has moved into the output register, even while it waits
// there. A stalled receiver holds the result and, once the next result is
// ready, holds the table too.
// cfg_valid/cfg_ready writes the install lifetime (reset value 10).
// Reset clears all valid bits and m_tvalid; no clearing pass.
`default_nettype none
`include "ip_fragment_slot_table_defines.svh"
module ip_fragment_slot_table #(
  parameter int SLOT_COUNT = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  // datagram_id, source_address, destination_address, protocol_number,
  // release_slot, zero pad
  input  wire logic [95:0]                  s_tdata,
  // op
  input  wire logic [ipfst_pkg::OP_W-1:0]   s_tuser,
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  // slot_index, expired_mask, zero pad
  output logic [15:0]                       m_tdata,
  // status
  output logic [ipfst_pkg::STAT_W-1:0]      m_tuser,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [ipfst_pkg::LIFE_W-1:0] cfg_data
);
  import ipfst_pkg::*;

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);
  localparam logic [CNT_W-1:0] SLOT_END = CNT_W'(SLOT_COUNT);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_INSTALL,
    S_DONE
  } state_t;

  state_t                state;
  op_t                   op_q;
  logic [KEY_W-1:0]      key_q;
  logic [LIFE_W-1:0]     lifetime;
  logic [SLOT_COUNT-1:0] valid;

  logic [CNT_W-1:0]      rd_cnt;
  logic                  dv;
  logic [IDX_W-1:0]      ev_idx;

  logic                  have_free;
  logic [IDX_W-1:0]      free_slot;
  logic                  have_old;
  logic [IDX_W-1:0]      old_slot;
  logic [LIFE_W-1:0]     old_cnt;
  logic [MASK_W-1:0]     mask;
  logic [IDX_W-1:0]      inst_slot;
  logic                  inst_free;

  logic [SLOT_W-1:0]     res_slot;
  status_t               res_status;
  logic [MASK_W-1:0]     res_mask;

  logic [SLOT_W-1:0]     out_slot;
  status_t               out_status;
  logic [MASK_W-1:0]     out_mask;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [ENTRY_W-1:0]    ram_wdata;
  logic                  ram_re;
  logic [ENTRY_W-1:0]    ram_rdata;

  logic                  accept;
  op_t                   in_op;
  logic [REL_W-1:0]      in_rel;
  logic [IDX_W-1:0]      rel_idx;
  logic                  rel_in_range;
  logic                  slot_valid;
  logic                  key_hit;
  logic [LIFE_W-1:0]     cur_cnt;
  logic [LIFE_W-1:0]     cnt_dec;
  logic                  take_free;
  logic                  take_old;
  logic                  have_free_next;
  logic [IDX_W-1:0]      free_slot_next;
  logic [IDX_W-1:0]      old_slot_next;
  logic                  expire;
  logic [MASK_W-1:0]     mask_next;
  logic                  last_slot;
  logic                  out_free;
  logic                  tick_wb;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign in_op     = op_t'(s_tuser);
  assign in_rel    = s_tdata[KEY_W +: REL_W];
  assign rel_idx   = IDX_W'(in_rel);
  assign rel_in_range = (32'(in_rel) < SLOT_COUNT);

  assign m_tdata = {5'd0, out_mask, out_slot};
  assign m_tuser = out_status;
  assign out_free = !m_tvalid || m_tready;

  assign slot_valid = valid[ev_idx];
  assign key_hit    = (ram_rdata[KEY_W-1:0] == key_q);
  assign cur_cnt    = ram_rdata[ENTRY_W-1 -: LIFE_W];
  assign cnt_dec    = cur_cnt - LIFE_W'(cur_cnt != '0);
  assign last_slot  = (ev_idx == LAST_IDX);

  assign take_free      = dv && !slot_valid;
  assign take_old       = dv && slot_valid && !key_hit && (!have_old || cur_cnt < old_cnt);
  assign have_free_next = have_free || take_free;
  assign free_slot_next = take_free ? ev_idx : free_slot;
  assign old_slot_next  = take_old ? ev_idx : old_slot;
  assign expire         = slot_valid && (cnt_dec == '0);
  assign mask_next      = expire ? (mask | (MASK_W'(1) << ev_idx)) : mask;

  assign tick_wb   = (state == S_WALK) && (op_q == OP_TICK) && dv;
  assign ram_re    = (state == S_WALK) && (rd_cnt < SLOT_END);
  assign ram_we    = (state == S_INSTALL) || (tick_wb && slot_valid);
  assign ram_waddr = (state == S_INSTALL) ? inst_slot : ev_idx;
  assign ram_wdata = (state == S_INSTALL) ? {lifetime, key_q}
                                          : {cnt_dec, ram_rdata[KEY_W-1:0]};

  ipfst_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(SLOT_COUNT)
  ) u_entry_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(rd_cnt[IDX_W-1:0]),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      lifetime <= LIFETIME_RESET;
    end else if (cfg_valid && cfg_ready) begin
      lifetime <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      valid    <= '0;
      m_tvalid <= 1'b0;
      dv       <= 1'b0;
    end else begin
      if ((state == S_DONE) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_q      <= in_op;
            key_q     <= s_tdata[KEY_W-1:0];
            rd_cnt    <= '0;
            dv        <= 1'b0;
            have_free <= 1'b0;
            have_old  <= 1'b0;
            old_cnt   <= COUNT_INIT;
            mask      <= '0;
            case (in_op) inside
              OP_LOOKUP, OP_TICK: begin
                state <= S_WALK;
              end
              OP_RELEASE: begin
                if (rel_in_range) begin
                  valid[rel_idx] <= 1'b0;
                end
                res_slot   <= in_rel;
                res_status <= ST_RELEASED;
                res_mask   <= '0;
                state      <= S_DONE;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_WALK: begin
          dv <= ram_re;
          if (ram_re) begin
            rd_cnt <= rd_cnt + CNT_W'(1);
            ev_idx <= rd_cnt[IDX_W-1:0];
          end
          if (dv) begin
            if (op_q == OP_TICK) begin
              mask <= mask_next;
              if (expire) begin
                valid[ev_idx] <= 1'b0;
              end
              if (last_slot) begin
                res_slot   <= '0;
                res_status <= ST_TICK;
                res_mask   <= mask_next;
                state      <= S_DONE;
              end
            end else if (slot_valid && key_hit) begin
              res_slot   <= SLOT_W'(ev_idx);
              res_status <= ST_MATCHED;
              res_mask   <= '0;
              state      <= S_DONE;
            end else begin
              have_free <= have_free_next;
              free_slot <= free_slot_next;
              if (take_old) begin
                have_old <= 1'b1;
                old_cnt  <= cur_cnt;
                old_slot <= ev_idx;
              end
              if (last_slot) begin
                inst_slot <= have_free_next ? free_slot_next : old_slot_next;
                inst_free <= have_free_next;
                state     <= S_INSTALL;
              end
            end
          end
        end
        S_INSTALL: begin
          valid[inst_slot] <= 1'b1;
          res_slot   <= SLOT_W'(inst_slot);
          res_status <= inst_free ? ST_NEW_FREE : ST_NEW_EVICT;
          res_mask   <= '0;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_slot   <= res_slot;
            out_status <= res_status;
            out_mask   <= res_mask;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `IPFST_ASSERT_IMP(a_ram_write_src, ram_we, (state == S_INSTALL) || tick_wb)
  `IPFST_ASSERT_NXT(a_install_sets_valid, state == S_INSTALL, valid[$past(inst_slot)])
  `IPFST_ASSERT_IMP(a_tick_slot_zero, m_tvalid && (out_status == ST_TICK), out_slot == '0)
  `IPFST_ASSERT_IMP(a_lookup_no_mask, m_tvalid && (out_status <= ST_NEW_EVICT), out_mask == '0)

endmodule
`default_nettype wire

/* src/ipfst_ram.sv */
`default_nettype none
module ipfst_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* verif/ip_fragment_slot_table_check.sv */
module ip_fragment_slot_table_check (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  input  wire logic                         s_tready,
  input  wire logic [95:0]                  s_tdata,
  input  wire logic [ipfst_pkg::OP_W-1:0]   s_tuser,
  input  wire logic                         m_tvalid,
  input  wire logic                         m_tready,
  input  wire logic [15:0]                  m_tdata,
  input  wire logic [ipfst_pkg::STAT_W-1:0] m_tuser,
  input  wire logic                         cfg_valid,
  input  wire logic                         cfg_ready,
  input  wire logic [ipfst_pkg::LIFE_W-1:0] cfg_data,
  output int                                fault_count,
  output int                                pending
);
  import ipfst_pkg::*;

  localparam int TABLE_SLOTS = 8;

  typedef struct packed {
    logic [PROTO_W-1:0] proto;
    logic [ADDR_W-1:0]  dst;
    logic [ADDR_W-1:0]  src;
    logic [ID_W-1:0]    id;
  } frag_key_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    status_t           status;
    logic [MASK_W-1:0] mask;
  } slot_result_t;

  logic [LIFE_W-1:0]      lifetime;
  logic [TABLE_SLOTS-1:0] live;
  frag_key_t              keys [TABLE_SLOTS];
  logic [LIFE_W-1:0]      left [TABLE_SLOTS];
  slot_result_t           outcome_q [$];

  task automatic report_fault(input string what);
    $display("%0t slot table mismatch: %s", $time, what);
    fault_count++;
  endtask

  task automatic apply_request(input logic [OP_W-1:0] code, input frag_key_t key,
                               input logic [REL_W-1:0] rel, output bit produced,
                               output slot_result_t r);
    bit hit;
    bit have_free;
    bit have_old;
    int free_slot;
    int old_slot;
    int victim;
    logic [LIFE_W-1:0] old_left;
    produced = 1'b1;
    r = '0;
    hit = 1'b0;
    have_free = 1'b0;
    have_old = 1'b0;
    free_slot = 0;
    old_slot = 0;
    old_left = COUNT_INIT;
    case (code)
      OP_LOOKUP: begin
        for (int i = 0; i < TABLE_SLOTS; i++) begin
          if (!hit) begin
            if (!live[i]) begin
              have_free = 1'b1;
              free_slot = i;
            end else if (keys[i] == key) begin
              hit = 1'b1;
              r.slot = i[SLOT_W-1:0];
              r.status = ST_MATCHED;
            end else if (!have_old || left[i] < old_left) begin
              have_old = 1'b1;
              old_left = left[i];
              old_slot = i;
            end
          end
        end
        if (!hit) begin
          victim = have_free ? free_slot : old_slot;
          live[victim] = 1'b1;
          keys[victim] = key;
          left[victim] = lifetime;
          r.slot = victim[SLOT_W-1:0];
          if (have_free) r.status = ST_NEW_FREE;
          else r.status = ST_NEW_EVICT;
        end
      end
      OP_TICK: begin
        for (int i = 0; i < TABLE_SLOTS; i++) begin
          if (live[i]) begin
            if (left[i] != 0) left[i] = left[i] - 1'b1;
            if (left[i] == 0) begin
              live[i] = 1'b0;
              r.mask[i] = 1'b1;
            end
          end
        end
        r.status = ST_TICK;
      end
      OP_RELEASE: begin
        if (rel < TABLE_SLOTS) live[rel] = 1'b0;
        r.slot = rel;
        r.status = ST_RELEASED;
      end
      default: produced = 1'b0;
    endcase
  endtask

  always @(posedge clk) begin : monitor
    slot_result_t want;
    slot_result_t got;
    slot_result_t fresh;
    bit produced;
    if (rst) begin
      lifetime = LIFETIME_RESET;
      live = '0;
      outcome_q.delete();
      fault_count = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.slot = m_tdata[SLOT_W-1:0];
        got.mask = m_tdata[SLOT_W +: MASK_W];
        got.status = status_t'(m_tuser);
        if (outcome_q.size() == 0) begin
          report_fault($sformatf("result with no request pending: slot %0d status %0d mask %h",
                                 got.slot, m_tuser, got.mask));
        end else begin
          want = outcome_q.pop_front();
          if (got.slot !== want.slot)
            report_fault($sformatf("slot_index %0d, want %0d", got.slot, want.slot));
          if (m_tuser !== want.status)
            report_fault($sformatf("status %0d, want %0d", m_tuser, want.status));
          if (got.mask !== want.mask)
            report_fault($sformatf("expired_mask %h, want %h", got.mask, want.mask));
        end
      end
      if (s_tvalid && s_tready) begin
        apply_request(s_tuser, s_tdata[KEY_W-1:0], s_tdata[KEY_W +: REL_W], produced, fresh);
        if (produced) outcome_q.push_back(fresh);
      end
      if (cfg_valid && cfg_ready) lifetime = cfg_data;
    end
    pending = outcome_q.size();
  end

endmodule

/* verif/ip_fragment_slot_table_test.sv */
module ip_fragment_slot_table_test;
  import ipfst_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 20;
  localparam int POOL_SIZE      = 12;
  localparam int PHASE_ITEMS    = 280;
  localparam int PAD_W          = 96 - REL_W - KEY_W;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [95:0]       s_tdata = '0;
  logic [OP_W-1:0]   s_tuser = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [15:0]       m_tdata;
  logic [STAT_W-1:0] m_tuser;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [LIFE_W-1:0] cfg_data = '0;

  int fault_count;
  int pending;
  int quiet_cycles = 0;
  int sink_hold = 0;
  bit sink_calm = 1'b0;
  bit src_calm = 1'b0;

  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  always #5 clk = ~clk;

  ip_fragment_slot_table u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  ip_fragment_slot_table_check u_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .fault_count (fault_count),
    .pending     (pending)
  );

  function automatic int idle_span();
    int pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom_range(1, 3);
    if (pick < 95) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [KEY_W-1:0] random_key();
    return {PROTO_W'($urandom), ADDR_W'($urandom), ADDR_W'($urandom), ID_W'($urandom)};
  endfunction

  // change one key field so near misses reach the full compare
  function automatic logic [KEY_W-1:0] varied_key(input logic [KEY_W-1:0] k);
    logic [KEY_W-1:0] v = k;
    case ($urandom_range(0, 3))
      0: v[ID_W-1:0] = ID_W'($urandom);
      1: v[ID_W +: ADDR_W] = ADDR_W'($urandom);
      2: v[ID_W + ADDR_W +: ADDR_W] = ADDR_W'($urandom);
      default: v[KEY_W-1 -: PROTO_W] = PROTO_W'($urandom);
    endcase
    return v;
  endfunction

  always @(negedge clk) begin
    if ($urandom_range(0, 399) == 0) sink_calm = !sink_calm;
    if (sink_hold == 0 && !sink_calm && $urandom_range(0, 3) == 0) sink_hold = idle_span();
    if (sink_hold > 0) begin
      m_tready <= 1'b0;
      sink_hold--;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("ip_fragment_slot_table_test: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(input logic [OP_W-1:0] code, input logic [KEY_W-1:0] key,
                              input logic [REL_W-1:0] rel);
    int gap;
    s_tuser <= code;
    s_tdata <= {{PAD_W{1'b0}}, rel, key};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    gap = 0;
    if (!src_calm && $urandom_range(0, 2) == 0) gap = idle_span();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_lifetime(input logic [LIFE_W-1:0] value);
    wait_drained();
    cfg_data <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int count);
    int done = 0;
    int pick;
    int tick_weight;
    logic [KEY_W-1:0] k;
    for (int j = 0; j < POOL_SIZE; j++) begin
      if (j > 0 && $urandom_range(0, 1) == 1) key_pool[j] = varied_key(key_pool[j-1]);
      else key_pool[j] = random_key();
    end
    tick_weight = $urandom_range(8, 30);
    while (done < count) begin
      if ($urandom_range(0, 99) == 0) src_calm = !src_calm;
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        send_request(OP_UNUSED, random_key(), REL_W'($urandom));
      end else begin
        if (pick < 4 + tick_weight) begin
          send_request(OP_TICK, random_key(), REL_W'($urandom));
        end else if (pick < 16 + tick_weight) begin
          send_request(OP_RELEASE, random_key(), REL_W'($urandom));
        end else begin
          if ($urandom_range(0, 6) == 0) k = random_key();
          else k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
          send_request(OP_LOOKUP, k, REL_W'($urandom));
        end
        done++;
      end
    end
  endtask

  initial begin : stimulus
    logic [LIFE_W-1:0] lifetimes [5];
    lifetimes = '{8'd1, 8'd255, 8'd0, 8'd2, 8'd128};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_request(OP_LOOKUP, '0, '0);
    send_request(OP_LOOKUP, '1, '1);
    send_request(OP_LOOKUP, '0, '0);
    send_request(OP_LOOKUP, {8'd0, 32'd0, 32'd0, 16'd1}, '0);
    send_request(OP_LOOKUP, {8'd0, 32'd0, 32'd1, 16'd0}, '0);
    send_request(OP_LOOKUP, {8'd0, 32'd1, 32'd0, 16'd0}, '0);
    send_request(OP_LOOKUP, {8'd1, 32'd0, 32'd0, 16'd0}, '0);
    send_request(OP_LOOKUP, random_key(), '0);
    send_request(OP_LOOKUP, random_key(), '0);
    send_request(OP_LOOKUP, random_key(), '0);
    send_request(OP_TICK, '0, '0);
    send_request(OP_LOOKUP, random_key(), '0);
    send_request(OP_RELEASE, '0, 3'd3);
    send_request(OP_RELEASE, '1, 3'd3);
    send_request(OP_RELEASE, '0, 3'd7);
    send_request(OP_UNUSED, '1, '1);
    send_request(OP_LOOKUP, '0, '0);
    send_request(OP_LOOKUP, {8'd0, 32'd0, 32'd0, 16'd1}, '0);
    send_request(OP_TICK, '1, '1);

    run_phase(PHASE_ITEMS);
    foreach (lifetimes[p]) begin
      write_lifetime(lifetimes[p]);
      run_phase(PHASE_ITEMS);
    end
    write_lifetime(LIFE_W'($urandom_range(3, 254)));
    run_phase(PHASE_ITEMS);

    wait_drained();
    if (fault_count == 0 && pending == 0) begin
      $display("ip_fragment_slot_table_test: clean");
    end else begin
      $display("ip_fragment_slot_table_test: errors");
    end
    $finish;
  end

endmodule

/* ip_fragment_slot_table.f */
+incdir+src
src/ipfst_pkg.sv
src/ipfst_ram.sv
src/ip_fragment_slot_table.sv
verif/ip_fragment_slot_table_check.sv
verif/ip_fragment_slot_table_test.sv
